// File: design/fcfs_pkg.sv
`timescale 1ns / 1ps
package fcfs_pkg;

    localparam int PCOUNT_W = 5;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_UNSTARTED = 3'd0,
        PH_READY     = 3'd1,
        PH_RUNNING   = 3'd2,
        PH_BLOCKED   = 3'd3,
        PH_DONE      = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_SWEEP    = 3'd1,
        S_SCAN     = 3'd2,
        S_DISPATCH = 3'd3,
        S_COUNT    = 3'd4,
        S_REPORT   = 3'd5
    } t_state;

    typedef struct packed {
        logic load;
        logic tick_go;
        logic sweep;
        logic scan;
        logic dispatch;
        logic count;
        logic report;
    } t_ctl;

endpackage

// File: design/fcfs_process_scheduler.sv
`timescale 1ns / 1ps
// First-come first-served process scheduler, simulated one tick per command.
// Command channel: a transaction is taken when start is high and busy is low.
//   Load (opcode 0) writes one slot in that cycle; busy stays low.
//   Start (opcode 1) sweeps every slot, one per cycle, with busy high
//   throughout. Opcode 3 is dropped.
//   Tick (opcode 2) scans the n slots in use twice through one slot port:
//   one pass for arrivals, I/O returns, the running process and the
//   longest-waiting ready slot, then a dispatch step, then a counter pass,
//   then the result strobe o_result_valid, for one cycle; busy drops with it.
//   A tick after every process is done goes straight to the strobe.
// Result channel: one transaction per tick, shown for the strobe cycle only;
//   the receiver cannot stall it.
// Configuration: i_cfg_we writes process_count from i_cfg_wdata. The user
//   must write it only while idle; the block does not enforce this.
// Reset (synchronous, active low): all slots unstarted, counters zero,
//   process_count 1. Slot contents stay undefined until loaded.
module fcfs_process_scheduler #(
    parameter int MAX_SLOTS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_slot,
    input  logic [15:0] i_arrival_cycle,
    input  logic [15:0] i_total_cpu_time,
    input  logic [7:0]  i_cpu_burst_length,
    input  logic [7:0]  i_io_multiplier,
    input  logic        i_cfg_we,
    input  logic [fcfs_pkg::PCOUNT_W-1:0] i_cfg_wdata,
    output logic        o_result_valid,
    output logic [15:0] o_cycle_number,
    output logic        o_running_valid,
    output logic [3:0]  o_running_slot,
    output logic        o_finished_valid,
    output logic [3:0]  o_finished_slot,
    output logic [15:0] o_finish_time,
    output logic [15:0] o_io_time_of_finished,
    output logic [15:0] o_wait_time_of_finished,
    output logic [15:0] o_blocked_cycles_total,
    output logic        o_all_done
);
    import fcfs_pkg::*;

    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNW = $clog2(MAX_SLOTS + 1);
    localparam int CW  = (CNW > PCOUNT_W) ? CNW : PCOUNT_W;

    logic [PCOUNT_W-1:0] r_pcount;
    logic [CW-1:0]       n_used;
    logic [SW-1:0]       idx;
    logic                tick_idle;
    t_ctl                ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= PCOUNT_W'(1);
        end else if (i_cfg_we) begin
            r_pcount <= i_cfg_wdata;
        end
    end

    // clamp the slot count to the table size
    assign n_used = (CW'(r_pcount) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(r_pcount);

    fcfs_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .SW        (SW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_opcode    (i_opcode),
        .i_tick_idle (tick_idle),
        .i_n         (n_used),
        .o_busy      (busy),
        .o_idx       (idx),
        .o_ctl       (ctl)
    );

    fcfs_slots #(
        .MAX_SLOTS (MAX_SLOTS),
        .TIME_BITS (TIME_BITS),
        .SW        (SW),
        .CW        (CW)
    ) u_slots (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_ctl                   (ctl),
        .i_idx                   (idx),
        .i_n                     (n_used),
        .i_slot                  (i_slot),
        .i_arrival_cycle         (i_arrival_cycle),
        .i_total_cpu_time        (i_total_cpu_time),
        .i_cpu_burst_length      (i_cpu_burst_length),
        .i_io_multiplier         (i_io_multiplier),
        .o_tick_idle             (tick_idle),
        .o_cycle_number          (o_cycle_number),
        .o_running_valid         (o_running_valid),
        .o_running_slot          (o_running_slot),
        .o_finished_valid        (o_finished_valid),
        .o_finished_slot         (o_finished_slot),
        .o_finish_time           (o_finish_time),
        .o_io_time_of_finished   (o_io_time_of_finished),
        .o_wait_time_of_finished (o_wait_time_of_finished),
        .o_blocked_cycles_total  (o_blocked_cycles_total),
        .o_all_done              (o_all_done)
    );

    assign o_result_valid = ctl.report;

endmodule

// File: design/fcfs_ctrl.sv
`timescale 1ns / 1ps
module fcfs_ctrl #(
    parameter int MAX_SLOTS = 16,
    parameter int SW = 4,
    parameter int CW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_opcode,
    input  logic          i_tick_idle,
    input  logic [CW-1:0] i_n,
    output logic          o_busy,
    output logic [SW-1:0] o_idx,
    output fcfs_pkg::t_ctl o_ctl
);
    import fcfs_pkg::*;

    t_state        r_state, n_state;
    logic [SW-1:0] r_idx, n_idx;
    logic          accept;
    logic          last_scan;
    logic          last_sweep;
    t_opcode       op;

    assign op         = t_opcode'(i_opcode);
    assign accept     = i_start && (r_state == S_IDLE);
    assign last_scan  = (CW'(r_idx) == (i_n - 1'b1));
    assign last_sweep = (r_idx == SW'(MAX_SLOTS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_START: n_state = S_SWEEP;
                        OP_TICK:  n_state = i_tick_idle ? S_REPORT : S_SCAN;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SWEEP:    n_state = last_sweep ? S_IDLE : S_SWEEP;
            S_SCAN:     n_state = last_scan ? S_DISPATCH : S_SCAN;
            S_DISPATCH: n_state = S_COUNT;
            S_COUNT:    n_state = last_scan ? S_REPORT : S_COUNT;
            S_REPORT:   n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_idx = '0;
        unique case (r_state)
            S_SWEEP:         n_idx = last_sweep ? '0 : r_idx + 1'b1;
            S_SCAN, S_COUNT: n_idx = last_scan ? '0 : r_idx + 1'b1;
            default:         n_idx = '0;
        endcase
    end

    always_comb begin
        o_busy           = (r_state != S_IDLE);
        o_idx            = r_idx;
        o_ctl.load       = accept && (op == OP_LOAD);
        o_ctl.tick_go    = accept && (op == OP_TICK);
        o_ctl.sweep      = (r_state == S_SWEEP);
        o_ctl.scan       = (r_state == S_SCAN);
        o_ctl.dispatch   = (r_state == S_DISPATCH);
        o_ctl.count      = (r_state == S_COUNT);
        o_ctl.report     = (r_state == S_REPORT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// File: design/fcfs_slots.sv
`timescale 1ns / 1ps
module fcfs_slots #(
    parameter int MAX_SLOTS = 16,
    parameter int TIME_BITS = 16,
    parameter int SW = 4,
    parameter int CW = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fcfs_pkg::t_ctl i_ctl,
    input  logic [SW-1:0]  i_idx,
    input  logic [CW-1:0]  i_n,
    input  logic [3:0]     i_slot,
    input  logic [15:0]    i_arrival_cycle,
    input  logic [15:0]    i_total_cpu_time,
    input  logic [7:0]     i_cpu_burst_length,
    input  logic [7:0]     i_io_multiplier,
    output logic           o_tick_idle,
    output logic [15:0]    o_cycle_number,
    output logic           o_running_valid,
    output logic [3:0]     o_running_slot,
    output logic           o_finished_valid,
    output logic [3:0]     o_finished_slot,
    output logic [15:0]    o_finish_time,
    output logic [15:0]    o_io_time_of_finished,
    output logic [15:0]    o_wait_time_of_finished,
    output logic [15:0]    o_blocked_cycles_total,
    output logic           o_all_done
);
    import fcfs_pkg::*;

    localparam int TW   = TIME_BITS;
    localparam int CMPW = (TW > 16) ? TW : 16;

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // loaded process table
    logic [15:0]   r_arrival [MAX_SLOTS];
    logic [15:0]   r_need    [MAX_SLOTS];
    logic [7:0]    r_burst   [MAX_SLOTS];
    logic [15:0]   r_ioburst [MAX_SLOTS];

    // run state
    t_phase        r_phase      [MAX_SLOTS];
    logic [7:0]    r_cpu_left   [MAX_SLOTS];
    logic [15:0]   r_io_left    [MAX_SLOTS];
    logic [TW-1:0] r_wait_now   [MAX_SLOTS];
    logic [TW-1:0] r_run_total  [MAX_SLOTS];
    logic [TW-1:0] r_io_total   [MAX_SLOTS];
    logic [TW-1:0] r_wait_total [MAX_SLOTS];
    logic [TW-1:0] r_cycle;
    logic [CW-1:0] r_done;
    logic [TW-1:0] r_bsum;

    // per-tick scratch
    logic [TW-1:0] r_cyc_out;
    logic          r_seen_run;
    logic          r_run_ok;
    logic [SW-1:0] r_run_slot;
    logic          r_fin;
    logic [SW-1:0] r_fslot;
    logic [TW-1:0] r_ftime;
    logic [TW-1:0] r_fio;
    logic [TW-1:0] r_fwait;
    logic          r_any;
    logic [SW-1:0] r_best;
    logic [TW-1:0] r_bw;

    t_phase        p;
    t_phase        a_ph;
    logic [TW-1:0] a_wait;
    logic [15:0]   a_io;
    logic          a_fin;
    logic          a_run;
    logic          a_cand;
    logic [SW-1:0] load_idx;
    logic          load_ok;

    assign load_idx = SW'(i_slot);
    assign load_ok  = ({28'd0, i_slot} < MAX_SLOTS);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && load_ok) begin
            r_arrival[load_idx] <= i_arrival_cycle;
            r_need[load_idx]    <= i_total_cpu_time;
            r_burst[load_idx]   <= i_cpu_burst_length;
            r_ioburst[load_idx] <= 16'(i_cpu_burst_length) * 16'(i_io_multiplier);
        end
    end

    // scan step: arrivals, returns from I/O, running process, candidate search
    always_comb begin
        p      = r_phase[i_idx];
        a_ph   = p;
        a_wait = r_wait_now[i_idx];
        a_io   = r_io_left[i_idx];
        a_fin  = 1'b0;
        a_run  = 1'b0;
        unique case (p)
            PH_UNSTARTED: begin
                if (CMPW'(r_arrival[i_idx]) == CMPW'(r_cycle)) begin
                    a_ph   = PH_READY;
                    a_wait = '0;
                end
            end
            PH_BLOCKED: begin
                if (r_io_left[i_idx] == '0) begin
                    a_ph   = PH_READY;
                    a_wait = '0;
                end
            end
            PH_RUNNING: begin
                if (!r_seen_run) begin
                    if (CMPW'(r_run_total[i_idx]) == CMPW'(r_need[i_idx])) begin
                        a_ph  = PH_DONE;
                        a_fin = 1'b1;
                    end else if (r_cpu_left[i_idx] == '0) begin
                        a_ph = PH_BLOCKED;
                        a_io = r_ioburst[i_idx];
                    end else begin
                        a_run = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        a_cand = (a_ph == PH_READY) && (!r_any || (a_wait > r_bw));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_phase[i]      <= PH_UNSTARTED;
                r_cpu_left[i]   <= '0;
                r_io_left[i]    <= '0;
                r_wait_now[i]   <= '0;
                r_run_total[i]  <= '0;
                r_io_total[i]   <= '0;
                r_wait_total[i] <= '0;
            end
            r_cycle    <= '0;
            r_done     <= '0;
            r_bsum     <= '0;
            r_seen_run <= 1'b0;
            r_run_ok   <= 1'b0;
            r_fin      <= 1'b0;
            r_any      <= 1'b0;
        end else begin
            if (i_ctl.sweep) begin
                r_phase[i_idx]      <= PH_UNSTARTED;
                r_cpu_left[i_idx]   <= r_burst[i_idx];
                r_io_left[i_idx]    <= r_ioburst[i_idx];
                r_wait_now[i_idx]   <= '0;
                r_run_total[i_idx]  <= '0;
                r_io_total[i_idx]   <= '0;
                r_wait_total[i_idx] <= '0;
                if (i_idx == '0) begin
                    r_cycle <= '0;
                    r_done  <= '0;
                    r_bsum  <= '0;
                end
            end

            if (i_ctl.tick_go) begin
                r_cyc_out  <= r_cycle;
                r_seen_run <= 1'b0;
                r_run_ok   <= 1'b0;
                r_run_slot <= '0;
                r_fin      <= 1'b0;
                r_fslot    <= '0;
                r_ftime    <= '0;
                r_fio      <= '0;
                r_fwait    <= '0;
                r_any      <= 1'b0;
                r_best     <= '0;
                r_bw       <= '0;
            end

            if (i_ctl.scan) begin
                r_phase[i_idx]    <= a_ph;
                r_wait_now[i_idx] <= a_wait;
                r_io_left[i_idx]  <= a_io;
                if (p == PH_RUNNING) begin
                    r_seen_run <= 1'b1;
                end
                if (a_fin) begin
                    r_done  <= r_done + 1'b1;
                    r_fin   <= 1'b1;
                    r_fslot <= i_idx;
                    r_ftime <= r_cycle;
                    r_fio   <= r_io_total[i_idx];
                    r_fwait <= r_wait_total[i_idx];
                end
                if (a_run) begin
                    r_run_ok   <= 1'b1;
                    r_run_slot <= i_idx;
                end
                if (a_cand) begin
                    r_any  <= 1'b1;
                    r_best <= i_idx;
                    r_bw   <= a_wait;
                end
            end

            if (i_ctl.dispatch) begin
                if (!r_run_ok && r_any) begin
                    r_phase[r_best]    <= PH_RUNNING;
                    r_cpu_left[r_best] <= r_burst[r_best];
                    r_run_ok           <= 1'b1;
                    r_run_slot         <= r_best;
                end
                r_cycle <= sat_inc(r_cycle);
            end

            if (i_ctl.count) begin
                unique case (r_phase[i_idx])
                    PH_RUNNING: begin
                        r_run_total[i_idx] <= sat_inc(r_run_total[i_idx]);
                        if (r_cpu_left[i_idx] != '0) begin
                            r_cpu_left[i_idx] <= r_cpu_left[i_idx] - 1'b1;
                        end
                    end
                    PH_BLOCKED: begin
                        r_io_total[i_idx] <= sat_inc(r_io_total[i_idx]);
                        if (r_io_left[i_idx] != '0) begin
                            r_io_left[i_idx] <= r_io_left[i_idx] - 1'b1;
                        end
                        r_bsum <= sat_inc(r_bsum);
                    end
                    PH_READY: begin
                        r_wait_now[i_idx]   <= sat_inc(r_wait_now[i_idx]);
                        r_wait_total[i_idx] <= sat_inc(r_wait_total[i_idx]);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_tick_idle             = (r_done >= i_n);
    assign o_cycle_number          = 16'(r_cyc_out);
    assign o_running_valid         = r_run_ok;
    assign o_running_slot          = 4'(r_run_slot);
    assign o_finished_valid        = r_fin;
    assign o_finished_slot         = 4'(r_fslot);
    assign o_finish_time           = 16'(r_ftime);
    assign o_io_time_of_finished   = 16'(r_fio);
    assign o_wait_time_of_finished = 16'(r_fwait);
    assign o_blocked_cycles_total  = 16'(r_bsum);
    assign o_all_done              = o_tick_idle;

endmodule

// File: design/fcfs_checker.sv
`timescale 1ns / 1ps
module fcfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_opcode,
    input logic        o_result_valid,
    input logic        o_running_valid,
    input logic [3:0]  o_running_slot,
    input logic        o_finished_valid,
    input logic [15:0] o_finish_time
);
    import fcfs_pkg::*;

    // a result only closes a tick that was running
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe outside a tick");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid && !busy)
        else $error("result strobe longer than one cycle");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_TICK)) |=> busy)
        else $error("tick accepted without going busy");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_LOAD)) |=> !busy && !o_result_valid)
        else $error("load caused activity");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_running_valid || (o_running_slot == 4'd0)) &&
                           (o_finished_valid || (o_finish_time == 16'd0)))
        else $error("unused result field not zero");

endmodule

bind fcfs_process_scheduler fcfs_checker u_fcfs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_opcode         (i_opcode),
    .o_result_valid   (o_result_valid),
    .o_running_valid  (o_running_valid),
    .o_running_slot   (o_running_slot),
    .o_finished_valid (o_finished_valid),
    .o_finish_time    (o_finish_time)
);

// File: tb/sv/fcfs_schedule_checker.sv
`timescale 1ns / 1ps
module fcfs_schedule_checker
    import fcfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_slot,
    input  logic [15:0] i_arrival_cycle,
    input  logic [15:0] i_total_cpu_time,
    input  logic [7:0]  i_cpu_burst_length,
    input  logic [7:0]  i_io_multiplier,
    input  logic        i_cfg_we,
    input  logic [PCOUNT_W-1:0] i_cfg_wdata,
    input  logic        i_result_valid,
    input  logic [15:0] i_cycle_number,
    input  logic        i_running_valid,
    input  logic [3:0]  i_running_slot,
    input  logic        i_finished_valid,
    input  logic [3:0]  i_finished_slot,
    input  logic [15:0] i_finish_time,
    input  logic [15:0] i_io_time_of_finished,
    input  logic [15:0] i_wait_time_of_finished,
    input  logic [15:0] i_blocked_cycles_total,
    input  logic        i_all_done,
    output int          o_errors,
    output int          o_pending,
    output int          o_ticks_seen,
    output int          o_finishes_seen
);

    localparam int SLOTS = 16;
    localparam int unsigned TMAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] cycle;
        logic        run_v;
        logic [3:0]  run_slot;
        logic        fin_v;
        logic [3:0]  fin_slot;
        logic [15:0] fin_time;
        logic [15:0] fin_io;
        logic [15:0] fin_wait;
        logic [15:0] blocked;
        logic        all_done;
    } tick_report_t;

    // scheduler state, mirrored
    int unsigned arrival_at[SLOTS], cpu_need[SLOTS], burst_len[SLOTS], io_burst[SLOTS];
    t_phase      ph[SLOTS];
    int unsigned cpu_rem[SLOTS], io_rem[SLOTS], waiting[SLOTS];
    int unsigned ran[SLOTS], io_sum[SLOTS], wait_sum[SLOTS];
    int unsigned cycle_now, finished_cnt, blocked_all, proc_count;

    tick_report_t expected_reports[$];

    function automatic int unsigned sat_up(int unsigned v);
        return (v >= TMAX) ? TMAX : v + 1;
    endfunction

    function automatic int unsigned down0(int unsigned v);
        return (v == 0) ? 0 : v - 1;
    endfunction

    task automatic begin_run();
        for (int i = 0; i < SLOTS; i++) begin
            ph[i] = PH_UNSTARTED;
            cpu_rem[i] = burst_len[i];
            io_rem[i] = io_burst[i];
            waiting[i] = 0; ran[i] = 0; io_sum[i] = 0; wait_sum[i] = 0;
        end
        cycle_now = 0;
        finished_cnt = 0;
        blocked_all = 0;
    endtask

    task automatic schedule_tick(output tick_report_t r);
        int unsigned n;
        int unsigned best, best_wait;
        logic any, seen;
        r = '0;
        n = (proc_count > SLOTS) ? SLOTS : proc_count;
        r.cycle = cycle_now[15:0];
        if (finished_cnt < n) begin
            for (int i = 0; i < n; i++)
                if (ph[i] == PH_UNSTARTED && arrival_at[i] == cycle_now) begin
                    ph[i] = PH_READY;
                    waiting[i] = 0;
                end
            for (int i = 0; i < n; i++)
                if (ph[i] == PH_BLOCKED && io_rem[i] == 0) begin
                    ph[i] = PH_READY;
                    waiting[i] = 0;
                end
            seen = 0;
            for (int i = 0; i < n; i++) begin
                if (!seen && ph[i] == PH_RUNNING) begin
                    seen = 1;
                    if (ran[i] == cpu_need[i]) begin
                        ph[i] = PH_DONE;
                        finished_cnt++;
                        r.fin_v = 1;
                        r.fin_slot = i[3:0];
                        r.fin_time = cycle_now[15:0];
                        r.fin_io = io_sum[i][15:0];
                        r.fin_wait = wait_sum[i][15:0];
                    end else if (cpu_rem[i] == 0) begin
                        ph[i] = PH_BLOCKED;
                        io_rem[i] = io_burst[i];
                    end else begin
                        r.run_v = 1;
                        r.run_slot = i[3:0];
                    end
                end
            end
            if (!r.run_v) begin
                any = 0; best = 0; best_wait = 0;
                for (int i = 0; i < n; i++)
                    if (ph[i] == PH_READY && (!any || waiting[i] > best_wait)) begin
                        any = 1; best = i; best_wait = waiting[i];
                    end
                if (any) begin
                    ph[best] = PH_RUNNING;
                    cpu_rem[best] = burst_len[best];
                    r.run_v = 1;
                    r.run_slot = best[3:0];
                end
            end
            for (int i = 0; i < n; i++) begin
                case (ph[i])
                    PH_RUNNING: begin
                        ran[i] = sat_up(ran[i]);
                        cpu_rem[i] = down0(cpu_rem[i]);
                    end
                    PH_BLOCKED: begin
                        io_sum[i] = sat_up(io_sum[i]);
                        io_rem[i] = down0(io_rem[i]);
                        blocked_all = sat_up(blocked_all);
                    end
                    PH_READY: begin
                        waiting[i] = sat_up(waiting[i]);
                        wait_sum[i] = sat_up(wait_sum[i]);
                    end
                    default: ;
                endcase
            end
            cycle_now = sat_up(cycle_now);
        end
        r.blocked = blocked_all[15:0];
        r.all_done = (finished_cnt >= n);
    endtask

    task automatic report_mismatch(string field, int unsigned got, int unsigned exp);
        $display("%0t: tick result mismatch on %s: got %0d, expected %0d",
                 $realtime, field, got, exp);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_ticks_seen = 0;
        o_finishes_seen = 0;
    end

    always @(posedge i_clk) begin
        tick_report_t r, e;
        int unsigned prod;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                arrival_at[i] = 0; cpu_need[i] = 0; burst_len[i] = 0; io_burst[i] = 0;
            end
            begin_run();
            proc_count = 1;
            expected_reports.delete();
        end else begin
            if (i_result_valid) begin
                o_ticks_seen++;
                if (i_finished_valid) o_finishes_seen++;
                if (expected_reports.size() == 0) begin
                    $display("%0t: tick result with no tick outstanding", $realtime);
                    o_errors++;
                end else begin
                    e = expected_reports.pop_front();
                    if (i_cycle_number != e.cycle)
                        report_mismatch("cycle_number", i_cycle_number, e.cycle);
                    if (i_running_valid != e.run_v)
                        report_mismatch("running_valid", i_running_valid, e.run_v);
                    if (i_running_slot != e.run_slot)
                        report_mismatch("running_slot", i_running_slot, e.run_slot);
                    if (i_finished_valid != e.fin_v)
                        report_mismatch("finished_valid", i_finished_valid, e.fin_v);
                    if (i_finished_slot != e.fin_slot)
                        report_mismatch("finished_slot", i_finished_slot, e.fin_slot);
                    if (i_finish_time != e.fin_time)
                        report_mismatch("finish_time", i_finish_time, e.fin_time);
                    if (i_io_time_of_finished != e.fin_io)
                        report_mismatch("io_time_of_finished", i_io_time_of_finished,
                                        e.fin_io);
                    if (i_wait_time_of_finished != e.fin_wait)
                        report_mismatch("wait_time_of_finished", i_wait_time_of_finished,
                                        e.fin_wait);
                    if (i_blocked_cycles_total != e.blocked)
                        report_mismatch("blocked_cycles_total", i_blocked_cycles_total,
                                        e.blocked);
                    if (i_all_done != e.all_done)
                        report_mismatch("all_done", i_all_done, e.all_done);
                end
            end
            if (i_cfg_we)
                proc_count = i_cfg_wdata;
            if (start && !busy) begin
                case (t_opcode'(i_opcode))
                    OP_LOAD: begin
                        prod = i_cpu_burst_length * i_io_multiplier;
                        arrival_at[i_slot] = i_arrival_cycle;
                        cpu_need[i_slot] = i_total_cpu_time;
                        burst_len[i_slot] = i_cpu_burst_length;
                        io_burst[i_slot] = (prod > TMAX) ? TMAX : prod;
                    end
                    OP_START: begin_run();
                    OP_TICK: begin
                        schedule_tick(r);
                        expected_reports.push_back(r);
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

// File: tb/sv/fcfs_process_scheduler_test.sv
`timescale 1ns / 1ps
module fcfs_process_scheduler_test;
    import fcfs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [3:0]  i_slot;
    logic [15:0] i_arrival_cycle;
    logic [15:0] i_total_cpu_time;
    logic [7:0]  i_cpu_burst_length;
    logic [7:0]  i_io_multiplier;
    logic        i_cfg_we;
    logic [PCOUNT_W-1:0] i_cfg_wdata;
    logic        o_result_valid;
    logic [15:0] o_cycle_number;
    logic        o_running_valid;
    logic [3:0]  o_running_slot;
    logic        o_finished_valid;
    logic [3:0]  o_finished_slot;
    logic [15:0] o_finish_time;
    logic [15:0] o_io_time_of_finished;
    logic [15:0] o_wait_time_of_finished;
    logic [15:0] o_blocked_cycles_total;
    logic        o_all_done;

    int errors, pending, ticks_seen, finishes_seen;
    int commands_sent, settings_used;

    fcfs_process_scheduler dut (.*);

    fcfs_schedule_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_slot, .i_arrival_cycle,
        .i_total_cpu_time, .i_cpu_burst_length, .i_io_multiplier, .i_cfg_we, .i_cfg_wdata,
        .i_result_valid(o_result_valid), .i_cycle_number(o_cycle_number),
        .i_running_valid(o_running_valid), .i_running_slot(o_running_slot),
        .i_finished_valid(o_finished_valid), .i_finished_slot(o_finished_slot),
        .i_finish_time(o_finish_time), .i_io_time_of_finished(o_io_time_of_finished),
        .i_wait_time_of_finished(o_wait_time_of_finished),
        .i_blocked_cycles_total(o_blocked_cycles_total), .i_all_done(o_all_done),
        .o_errors(errors), .o_pending(pending), .o_ticks_seen(ticks_seen),
        .o_finishes_seen(finishes_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly back-to-back or short gaps, now and then a long one
    task automatic idle_gap();
        int unsigned g;
        g = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        if (g > 0) begin
            start = 0;
            i_opcode = 2'($urandom);
            i_slot = 4'($urandom);
            repeat (g) @(negedge i_clk);
        end
    endtask

    // called at a falling edge; returns at a falling edge after acceptance and any idle gap
    task automatic issue(t_opcode op, logic [3:0] s, logic [15:0] arr, logic [15:0] need,
                         logic [7:0] burst, logic [7:0] mult);
        i_opcode = op;
        i_slot = s;
        i_arrival_cycle = arr;
        i_total_cpu_time = need;
        i_cpu_burst_length = burst;
        i_io_multiplier = mult;
        start = 1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        commands_sent++;
        if ($urandom_range(0, 3) != 0) idle_gap();
    endtask

    task automatic issue_op(t_opcode op);
        issue(op, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic load_random(logic [3:0] s);
        logic [15:0] arr, need;
        logic [7:0] burst, mult;
        arr = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        need = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, 12));
        case ($urandom_range(0, 7))
            0: burst = 8'd255;
            1: burst = 8'($urandom_range(1, 255));
            default: burst = 8'($urandom_range(1, 4));
        endcase
        mult = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                          : 8'($urandom_range(1, 3));
        issue(OP_LOAD, s, arr, need, burst, mult);
    endtask

    // let the block settle, then change the slot count
    task automatic set_count(logic [PCOUNT_W-1:0] v);
        start = 0;
        while (busy) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        i_cfg_wdata = 5'($urandom);
        settings_used++;
    endtask

    initial begin
        logic [PCOUNT_W-1:0] counts[8];
        int unsigned roll;
        counts = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd3};
        start = 0;
        i_opcode = OP_NONE;
        i_slot = 0;
        i_arrival_cycle = 0;
        i_total_cpu_time = 0;
        i_cpu_burst_length = 0;
        i_io_multiplier = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        commands_sent = 0;
        settings_used = 0;
        i_rst_n = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;

        // directed: every slot loaded, some with field extremes, then a short run on four slots
        set_count(5'd4);
        issue(OP_LOAD, 4'd0, 16'd0, 16'd1, 8'd1, 8'd1);
        issue(OP_LOAD, 4'd1, 16'd0, 16'd3, 8'd1, 8'd2);
        issue(OP_LOAD, 4'd2, 16'd1, 16'd4, 8'd255, 8'd255);
        issue(OP_LOAD, 4'd3, 16'd2, 16'd2, 8'd2, 8'd1);
        for (int s = 4; s < 15; s++)
            issue(OP_LOAD, 4'(s), 16'hFFFF, 16'hFFFF, 8'hAA, 8'h55);
        issue(OP_LOAD, 4'd15, 16'h5555, 16'hAAAA, 8'h55, 8'hAA);
        issue_op(OP_START);
        issue_op(OP_NONE);
        repeat (6) issue_op(OP_TICK);

        // random phases: new count, reload, start, then mostly ticks with some noise
        for (int ph = 0; ph < 8; ph++) begin
            set_count((ph < 7) ? counts[ph + 1] : 5'($urandom));
            for (int s = 0; s < 16; s++) load_random(4'(s));
            issue_op(OP_START);
            for (int k = 0; k < 32; k++) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) load_random(4'($urandom));
                else if (roll == 1) issue_op(OP_NONE);
                else if (roll == 2 && k > 20) issue_op(OP_START);
                else issue_op(OP_TICK);
            end
        end

        start = 0;
        while (busy) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("Covered %0d commands over %0d slot-count settings.",
                 commands_sent, settings_used);
        $display("Checked %0d tick results, %0d of them reporting a finish.",
                 ticks_seen, finishes_seen);
        if (errors == 0 && pending == 0) begin
            $display("fcfs_process_scheduler_test: PASS");
        end else begin
            if (pending != 0) $display("%0d tick results never arrived", pending);
            $display("fcfs_process_scheduler_test: FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out waiting for the scheduler");
        $display("fcfs_process_scheduler_test: FAIL");
        $finish;
    end

endmodule
